### rtl/gbf_pkg.sv
// gbf_pkg: shared codes, constants and saturating helpers for the gravity body unit
// used by the top level of the unit; no dependencies
`default_nettype none

package gbf_pkg;

  // item opcodes
  localparam logic [2:0] OP_LOAD_POS  = 3'd0;
  localparam logic [2:0] OP_LOAD_VEL  = 3'd1;
  localparam logic [2:0] OP_ADD_FORCE = 3'd2;
  localparam logic [2:0] OP_ATTRACT   = 3'd3;
  localparam logic [2:0] OP_STEP      = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZDIST = 2'd1;
  localparam logic [1:0] ST_ZMASS = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MASS = 2'd0;
  localparam logic [1:0] CFG_DT   = 2'd1;
  localparam logic [1:0] CFG_GRAV = 2'd2;

  // reset values of the configuration registers
  localparam logic [63:0] MASS_RST = 64'h0000_0001_0000_0000;
  localparam logic [63:0] DT_RST   = 64'h0000_0001_0000_0000;
  localparam logic [31:0] GRAV_RST = 32'd18785;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] val;
    logic        sat;
  } sres_t;

  // magnitude of a two's complement word
  function automatic logic [63:0] magof(input logic [63:0] x);
    magof = x[63] ? (~x + 64'd1) : x;
  endfunction

  // sign and magnitude to two's complement, clamped
  function automatic sres_t signed_of(input logic [127:0] mag, input logic neg);
    sres_t r;
    if (!neg) begin
      if (mag[127:63] != '0) begin
        r.val = SMAX;
        r.sat = 1'b1;
      end else begin
        r.val = mag[63:0];
        r.sat = 1'b0;
      end
    end else begin
      if ((mag[127:64] != '0) || (mag[63:0] > SMIN)) begin
        r.val = SMIN;
        r.sat = 1'b1;
      end else begin
        r.val = ~mag[63:0] + 64'd1;
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

  // two's complement add, clamped
  function automatic sres_t sat_add(input logic [63:0] a, input logic [63:0] b);
    sres_t       r;
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      r.val = a[63] ? SMIN : SMAX;
      r.sat = 1'b1;
    end else begin
      r.val = s;
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/gbf_mul.sv
// gbf_mul: 64 x 64 unsigned multiplier, one 32 x 32 partial product a cycle
// depends on nothing but its ports
`default_nettype none

module gbf_mul (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output logic              done_o,
  output logic [127:0]      prod_o
);

  logic [63:0]  a_q, b_q;
  logic [63:0]  pp_q;
  logic [127:0] acc_q;
  logic [2:0]   cnt_q;
  logic [1:0]   prv_q;
  logic         busy_q, done_q;
  logic [31:0]  ah, bh;
  logic [127:0] pp_sh;

  // pick the halves for this partial product
  assign ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  // align the previous partial product
  always_comb begin
    unique case (prv_q)
      2'd0:    pp_sh = {64'd0, pp_q};
      2'd3:    pp_sh = {pp_q, 64'd0};
      default: pp_sh = {32'd0, pp_q, 32'd0};
    endcase
  end

  // sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands, partial product and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q  <= ah * bh;
        prv_q <= cnt_q[1:0];
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

### rtl/gbf_div.sv
// gbf_div: 128 by 64 bit unsigned restoring divider, one quotient bit a cycle
// depends on nothing but its ports
`default_nettype none

module gbf_div (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] num_i,
  input  wire logic [63:0]  den_i,
  output logic              done_o,
  output logic [127:0]      quot_o
);

  logic [127:0] num_q;
  logic [63:0]  den_q, rem_q;
  logic [6:0]   cnt_q;
  logic         busy_q, done_q;
  logic [63:0]  sh, diff;
  logic         take;

  // one shift-subtract step
  assign sh   = {rem_q[62:0], num_q[127]};
  assign diff = sh - den_q;
  assign take = rem_q[63] || (sh >= den_q);

  // sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out, quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? diff : sh;
      num_q <= {num_q[126:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

### rtl/gbf_sqrt.sv
// gbf_sqrt: floor square root of a 128 bit value, one root bit a cycle
// depends on nothing but its ports
`default_nettype none

module gbf_sqrt (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] rad_i,
  output logic              done_o,
  output logic [63:0]       root_o
);

  logic [127:0] rad_q;
  logic [65:0]  rem_q;
  logic [63:0]  root_q;
  logic [5:0]   cnt_q;
  logic         busy_q, done_q;
  logic [67:0]  rem_sh, trial, rem_sub;
  logic         take;

  // bring down two bits and try the next root bit
  assign rem_sh  = {rem_q, rad_q[127:126]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign take    = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  // sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[125:0], 2'b00};
      rem_q  <= take ? rem_sub[65:0] : rem_sh[65:0];
      root_q <= {root_q[62:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

### rtl/gravity_body_force_and_step_unit.sv
// gravity_body_force_and_step_unit: top level, sequencer and body state
// uses gbf_pkg, gbf_mul, gbf_div and gbf_sqrt
`default_nettype none

// One body with position, velocity and force sum (signed Q32.32 three-vectors),
// driven by one opcode per input transaction; every transaction returns the
// full state and a status. Loads, force add and clear go from accept through
// the dispatch and done states into the output register. Attraction and a time
// step are dominated by the shared 128-step divider (one quotient bit a cycle),
// used up to twice plus once per axis for attraction and once per axis for a
// step, with the 64-step square root and the multiplier adding the rest.
// The input side is not ready while a transaction is in work; a finished
// result waits in the output register while the next one is accepted.
// Configuration writes are taken every cycle and must only come while idle.
module gravity_body_force_and_step_unit
  import gbf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         opcode_i,
  input  wire logic signed [63:0] vec_x_i,
  input  wire logic signed [63:0] vec_y_i,
  input  wire logic signed [63:0] vec_z_i,
  input  wire logic [63:0]        other_mass_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [63:0]      pos_x_o,
  output logic signed [63:0]      pos_y_o,
  output logic signed [63:0]      pos_z_o,
  output logic signed [63:0]      vel_x_o,
  output logic signed [63:0]      vel_y_o,
  output logic signed [63:0]      vel_z_o,
  output logic signed [63:0]      acc_force_x_o,
  output logic signed [63:0]      acc_force_y_o,
  output logic signed [63:0]      acc_force_z_o,
  output logic [1:0]              status_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_DIFF   = 5'd2;
  localparam logic [4:0] S_CHK    = 5'd3;
  localparam logic [4:0] S_SQ     = 5'd4;
  localparam logic [4:0] S_SQRT   = 5'd5;
  localparam logic [4:0] S_GM     = 5'd6;
  localparam logic [4:0] S_GMM    = 5'd7;
  localparam logic [4:0] S_T      = 5'd8;
  localparam logic [4:0] S_U      = 5'd9;
  localparam logic [4:0] S_CF     = 5'd10;
  localparam logic [4:0] S_CD     = 5'd11;
  localparam logic [4:0] S_ADV_A  = 5'd12;
  localparam logic [4:0] S_ADV_DV = 5'd13;
  localparam logic [4:0] S_ADV_H  = 5'd14;
  localparam logic [4:0] S_ADV_V  = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  // control state
  logic [4:0]  state_q, state_d;
  logic [1:0]  ax_q, ax_d;
  logic        issued_q, issued_d;
  logic        sat_q, sat_d;
  logic [1:0]  stat_q, stat_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] mass_q, dt_q;
  logic [31:0] grav_q;

  // body state
  logic [2:0][63:0] pos_q, pos_d, vel_q, vel_d, frc_q, frc_d;

  // item and work registers
  logic [2:0]       op_q;
  logic [2:0][63:0] vin_q;
  logic [63:0]      om_q;
  logic [2:0][63:0] mag_q, mag_d;
  logic [2:0]       neg_q, neg_d;
  logic [127:0]     r2_q, r2_d;
  logic [63:0]      r_q, r_d, gm_q, gm_d, f_q, f_d, a_q, a_d, dv_q, dv_d, h_q, h_d;
  logic             load;

  // output register
  logic [2:0][63:0] opos_q, ovel_q, ofrc_q;
  logic [1:0]       ostat_q;

  // shared units
  logic         mul_start, mul_done, div_start, div_done, sq_start, sq_done;
  logic [63:0]  mul_a, mul_b, div_den, sq_root;
  logic [127:0] mul_res, div_num, div_res, r2_sum_w;
  logic [128:0] r2_sum;
  logic         use_mul, use_div, use_sq, unit_done;
  logic         in_acc;

  gbf_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_res)
  );

  gbf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_res)
  );

  gbf_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(r2_q),
    .done_o(sq_done), .root_o(sq_root)
  );

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // which unit a state uses and its operands
  always_comb begin
    use_mul = 1'b0;
    use_div = 1'b0;
    use_sq  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = r_q;
    unique case (state_q)
      S_SQ: begin
        use_mul = 1'b1;
        mul_a   = mag_q[ax_q];
        mul_b   = mag_q[ax_q];
      end
      S_SQRT: use_sq = 1'b1;
      S_GM: begin
        use_mul = 1'b1;
        mul_a   = {32'd0, grav_q};
        mul_b   = mass_q;
      end
      S_GMM: begin
        use_mul = 1'b1;
        mul_a   = gm_q;
        mul_b   = om_q;
      end
      S_T: begin
        use_div = 1'b1;
        div_num = mul_res;
      end
      S_U: begin
        use_div = 1'b1;
        div_num = {div_res[95:0], 32'd0};
      end
      S_CF: begin
        use_mul = 1'b1;
        mul_a   = f_q;
        mul_b   = mag_q[ax_q];
      end
      S_CD: begin
        use_div = 1'b1;
        div_num = mul_res;
      end
      S_ADV_A: begin
        use_div = 1'b1;
        div_num = {32'd0, magof(frc_q[ax_q]), 32'd0};
        div_den = mass_q;
      end
      S_ADV_DV: begin
        use_mul = 1'b1;
        mul_a   = magof(a_q);
        mul_b   = dt_q;
      end
      S_ADV_H: begin
        use_mul = 1'b1;
        mul_a   = magof(dv_q);
        mul_b   = dt_q;
      end
      S_ADV_V: begin
        use_mul = 1'b1;
        mul_a   = magof(vel_q[ax_q]);
        mul_b   = dt_q;
      end
      default: ;
    endcase
  end

  assign mul_start = use_mul && !issued_q;
  assign div_start = use_div && !issued_q;
  assign sq_start  = use_sq && !issued_q;
  assign unit_done = issued_q && ((use_mul && mul_done) || (use_div && div_done) ||
                                  (use_sq && sq_done));

  // running sum of squares, pinned at all ones on overflow
  assign r2_sum   = {1'b0, r2_q} + {1'b0, mul_res};
  assign r2_sum_w = r2_sum[128] ? '1 : r2_sum[127:0];

  // sequencer
  always_comb begin
    sres_t s1, s2, s3, s4;
    logic  sat_n;
    state_d  = state_q;
    ax_d     = ax_q;
    issued_d = issued_q;
    sat_d    = sat_q;
    stat_d   = stat_q;
    pos_d    = pos_q;
    vel_d    = vel_q;
    frc_d    = frc_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    r2_d     = r2_q;
    r_d      = r_q;
    gm_d     = gm_q;
    f_d      = f_q;
    a_d      = a_q;
    dv_d     = dv_q;
    h_d      = h_q;
    load     = 1'b0;
    s1       = '0;
    s2       = '0;
    s3       = '0;
    s4       = '0;
    sat_n    = sat_q;

    if (use_mul || use_div || use_sq) begin
      if (!issued_q) issued_d = 1'b1;
      else if (unit_done) issued_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DISP;
      end
      S_DISP: begin
        sat_d   = 1'b0;
        stat_d  = ST_OK;
        ax_d    = '0;
        state_d = S_DONE;
        unique case (op_q)
          OP_LOAD_POS: pos_d = vin_q;
          OP_LOAD_VEL: vel_d = vin_q;
          OP_ADD_FORCE: begin
            s1 = sat_add(frc_q[0], vin_q[0]);
            s2 = sat_add(frc_q[1], vin_q[1]);
            s3 = sat_add(frc_q[2], vin_q[2]);
            frc_d[0] = s1.val;
            frc_d[1] = s2.val;
            frc_d[2] = s3.val;
            if (s1.sat || s2.sat || s3.sat) stat_d = ST_SAT;
          end
          OP_ATTRACT: state_d = S_DIFF;
          OP_STEP: begin
            if (mass_q == '0) stat_d = ST_ZMASS;
            else state_d = S_ADV_A;
          end
          OP_CLEAR: frc_d = '0;
          default: ;
        endcase
      end
      // separation as sign and magnitude
      S_DIFF: begin
        if ($signed(vin_q[ax_q]) >= $signed(pos_q[ax_q])) begin
          mag_d[ax_q] = vin_q[ax_q] - pos_q[ax_q];
          neg_d[ax_q] = 1'b0;
        end else begin
          mag_d[ax_q] = pos_q[ax_q] - vin_q[ax_q];
          neg_d[ax_q] = 1'b1;
        end
        if (ax_q == 2'd2) begin
          ax_d    = '0;
          state_d = S_CHK;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      S_CHK: begin
        r2_d = '0;
        if ((mag_q[0] | mag_q[1] | mag_q[2]) == '0) begin
          stat_d  = ST_ZDIST;
          state_d = S_DONE;
        end else if ((mass_q == '0) || (om_q == '0)) begin
          stat_d  = ST_ZMASS;
          state_d = S_DONE;
        end else begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (unit_done) begin
          r2_d = r2_sum_w;
          if (ax_q == 2'd2) begin
            ax_d    = '0;
            state_d = S_SQRT;
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end
      end
      S_SQRT: begin
        if (unit_done) begin
          r_d     = sq_root;
          state_d = S_GM;
        end
      end
      S_GM: begin
        if (unit_done) begin
          gm_d    = mul_res[111:48];
          state_d = S_GMM;
        end
      end
      S_GMM: begin
        if (unit_done) state_d = S_T;
      end
      // magnitude of the pull, clamped
      S_T: begin
        if (unit_done) begin
          if (div_res[127:96] != '0) begin
            f_d     = SMAX;
            sat_d   = 1'b1;
            state_d = S_CF;
          end else begin
            state_d = S_U;
          end
        end
      end
      S_U: begin
        if (unit_done) begin
          if (div_res[127:63] != '0) begin
            f_d   = SMAX;
            sat_d = 1'b1;
          end else begin
            f_d = div_res[63:0];
          end
          state_d = S_CF;
        end
      end
      S_CF: begin
        if (unit_done) state_d = S_CD;
      end
      // per-axis component into the force sum
      S_CD: begin
        if (unit_done) begin
          s1 = signed_of(div_res, neg_q[ax_q]);
          s2 = sat_add(frc_q[ax_q], s1.val);
          frc_d[ax_q] = s2.val;
          sat_n = sat_q | s1.sat | s2.sat;
          sat_d = sat_n;
          if (ax_q == 2'd2) begin
            stat_d  = sat_n ? ST_SAT : ST_OK;
            state_d = S_DONE;
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = S_CF;
          end
        end
      end
      // acceleration
      S_ADV_A: begin
        if (unit_done) begin
          s1      = signed_of(div_res, frc_q[ax_q][63]);
          a_d     = s1.val;
          sat_d   = sat_q | s1.sat;
          state_d = S_ADV_DV;
        end
      end
      S_ADV_DV: begin
        if (unit_done) begin
          s1      = signed_of({32'd0, mul_res[127:32]}, frc_q[ax_q][63]);
          dv_d    = s1.val;
          sat_d   = sat_q | s1.sat;
          state_d = S_ADV_H;
        end
      end
      S_ADV_H: begin
        if (unit_done) begin
          s1      = signed_of({33'd0, mul_res[127:33]}, frc_q[ax_q][63]);
          h_d     = s1.val;
          sat_d   = sat_q | s1.sat;
          state_d = S_ADV_V;
        end
      end
      // position and velocity update for this axis
      S_ADV_V: begin
        if (unit_done) begin
          s1 = signed_of({32'd0, mul_res[127:32]}, vel_q[ax_q][63]);
          s2 = sat_add(pos_q[ax_q], s1.val);
          s3 = sat_add(s2.val, h_q);
          s4 = sat_add(vel_q[ax_q], dv_q);
          pos_d[ax_q] = s3.val;
          vel_d[ax_q] = s4.val;
          sat_n = sat_q | s1.sat | s2.sat | s3.sat | s4.sat;
          sat_d = sat_n;
          if (ax_q == 2'd2) begin
            stat_d  = sat_n ? ST_SAT : ST_OK;
            state_d = S_DONE;
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = S_ADV_A;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // control and body state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= '0;
      issued_q    <= 1'b0;
      sat_q       <= 1'b0;
      stat_q      <= ST_OK;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      vel_q       <= '0;
      frc_q       <= '0;
      mass_q      <= MASS_RST;
      dt_q        <= DT_RST;
      grav_q      <= GRAV_RST;
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      issued_q    <= issued_d;
      sat_q       <= sat_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      frc_q       <= frc_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MASS: mass_q <= cfg_data_i;
          CFG_DT:   dt_q   <= cfg_data_i;
          CFG_GRAV: grav_q <= cfg_data_i[31:0];
          default:  ;
        endcase
      end
    end
  end

  // work and output payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= opcode_i;
      vin_q[0] <= vec_x_i;
      vin_q[1] <= vec_y_i;
      vin_q[2] <= vec_z_i;
      om_q     <= other_mass_i;
    end
    mag_q <= mag_d;
    neg_q <= neg_d;
    r2_q  <= r2_d;
    r_q   <= r_d;
    gm_q  <= gm_d;
    f_q   <= f_d;
    a_q   <= a_d;
    dv_q  <= dv_d;
    h_q   <= h_d;
    if (load) begin
      opos_q  <= pos_q;
      ovel_q  <= vel_q;
      ofrc_q  <= frc_q;
      ostat_q <= stat_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = opos_q[0];
  assign pos_y_o       = opos_q[1];
  assign pos_z_o       = opos_q[2];
  assign vel_x_o       = ovel_q[0];
  assign vel_y_o       = ovel_q[1];
  assign vel_z_o       = ovel_q[2];
  assign acc_force_x_o = ofrc_q[0];
  assign acc_force_y_o = ofrc_q[1];
  assign acc_force_z_o = ofrc_q[2];
  assign status_o      = ostat_q;

endmodule

`default_nettype wire

### rtl/gbf_chk.sv
// gbf_chk: port-level checks for gravity_body_force_and_step_unit
// bound to the top level; no package needed
`default_nettype none

module gbf_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] pos_x_o,
  input wire logic [63:0] vel_x_o,
  input wire logic [63:0] acc_force_x_o,
  input wire logic [1:0]  status_o
);

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a transaction is in work");

  // a result appears only from the busy phase
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without a transaction in work");

  // result valid holds until taken
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result valid dropped before it was taken");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      ($stable(pos_x_o) && $stable(vel_x_o) && $stable(acc_force_x_o) &&
       $stable(status_o)))
    else $error("result payload changed while stalled");

endmodule

bind gravity_body_force_and_step_unit gbf_chk u_gbf_chk (.*);

`default_nettype wire
